### hw/rtl/tscd_pkg.sv
// Package with the widths, constants and pipeline layout of the triangle sample coverage core.
`default_nettype none
package tscd_pkg;
    localparam int FRAC_BITS  = 4;
    localparam int DEPTH_BITS = 16;
    localparam int SAMPLES    = 4;
    localparam int NSAMP      = 4;

    localparam int CW   = 16;
    localparam int ZW   = 16;
    localparam int PIXW = 11;
    localparam int EW   = CW + 1;
    localparam int SXW  = PIXW + FRAC_BITS;
    localparam int DXW  = ((SXW > CW) ? SXW : CW) + 2;
    localparam int PW   = EW + DXW;
    localparam int UW   = PW + 1;
    localparam int NW   = UW + 2;
    localparam int MW   = DEPTH_BITS + NW;
    localparam int NUMW = MW + 2;

    localparam logic [NW-1:0] AREA_THR = NW'((9 << (2 * FRAC_BITS)) / 10);

    localparam int FRONT = 6;
    localparam int LAST  = FRONT + DEPTH_BITS;
    localparam int NST   = LAST + 1;

    typedef struct packed {
        logic [DEPTH_BITS-1:0] az;
        logic [DEPTH_BITS-1:0] bz;
        logic [DEPTH_BITS-1:0] cz;
    } zset_t;

    typedef struct packed {
        logic [NSAMP-1:0] cov;
        logic             degen;
    } side_t;
endpackage
`default_nettype wire

### hw/rtl/tscd_divider.sv
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
module tscd_divider
    import tscd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic [DEPTH_BITS-1:0] adv,
    input  wire logic [NUMW-1:0]       num_in,
    input  wire logic [NW-1:0]         den_in,
    output logic [DEPTH_BITS-1:0]      quo
);
    logic [NUMW-1:0]       rem_reg [DEPTH_BITS];
    logic [NW-1:0]         den_reg [DEPTH_BITS];
    logic [DEPTH_BITS-1:0] q_reg   [DEPTH_BITS];

    for (genvar k = 0; k < DEPTH_BITS; k++) begin : g_step
        logic [NUMW-1:0]       rem_src;
        logic [NW-1:0]         den_src;
        logic [DEPTH_BITS-1:0] q_src;
        logic [NUMW-1:0]       den_sh;
        logic [NUMW-1:0]       rem_next;
        logic [DEPTH_BITS-1:0] q_next;

        if (k == 0) begin : g_first
            assign rem_src = num_in;
            assign den_src = den_in;
            assign q_src   = '0;
        end else begin : g_rest
            assign rem_src = rem_reg[k-1];
            assign den_src = den_reg[k-1];
            assign q_src   = q_reg[k-1];
        end

        // The quotient is known to fit, so the shifted divisor never loses bits.
        assign den_sh = NUMW'(den_src) << (DEPTH_BITS - 1 - k);

        always_comb
        begin
            rem_next = rem_src;
            q_next   = q_src;
            if (rem_src >= den_sh)
            begin
                rem_next = rem_src - den_sh;
                q_next[DEPTH_BITS-1-k] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_src;
                q_reg[k]   <= q_next;
            end
        end
    end

    assign quo = q_reg[DEPTH_BITS-1];
endmodule
`default_nettype wire

### hw/rtl/triangle_sample_coverage_depth_core.sv
// Top level: 4x supersampled triangle coverage and interpolated depth for one pixel.
//
// Input channel (in_valid/in_ready) carries one triangle (ax..cz) and one pixel.
// Output channel (out_valid/out_ready) returns the coverage mask, four sample
// depths and the degenerate flag for that item, in order.
// Samples sit at pixel offsets (.25,.25), (.75,.25), (.25,.75), (.75,.75).
// A sample on an edge counts as covered; uncovered samples report depth 0.
// A triangle whose doubled area is at most 0.9 pixel squared reports mask 0.
//
// An item passes through 23 register stages: six arithmetic stages (edges,
// cross products, areas, weights, depth products, sum), sixteen divider stages
// producing one quotient bit each, and the output register.
// Throughput is one item per cycle while the receiver is ready; every stage
// has its own valid bit.
// When the receiver stalls, a stage holds only if the stage after it is full,
// so bubbles are squeezed out and in_ready drops only once the pipe is full.
// Reset clears all valid bits; the pipeline then accepts at once.
`default_nettype none
module triangle_sample_coverage_depth_core
    import tscd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic signed [CW-1:0]   ax,
    input  wire logic signed [CW-1:0]   ay,
    input  wire logic [ZW-1:0]          az,
    input  wire logic signed [CW-1:0]   bx,
    input  wire logic signed [CW-1:0]   by_coord,
    input  wire logic [ZW-1:0]          bz,
    input  wire logic signed [CW-1:0]   cx,
    input  wire logic signed [CW-1:0]   cy,
    input  wire logic [ZW-1:0]          cz,
    input  wire logic [PIXW-1:0]        pixel_x,
    input  wire logic [PIXW-1:0]        pixel_y,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [3:0]                  sample_mask,
    output logic [15:0]                 depth_s0,
    output logic [15:0]                 depth_s1,
    output logic [15:0]                 depth_s2,
    output logic [15:0]                 depth_s3,
    output logic                        degenerate
);
    logic [NST-1:0] v_reg;
    logic [NST:0]   adv;

    always_comb
    begin
        adv[NST] = out_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[LAST];

    // Depths travel alongside the geometry until the product stage.
    zset_t zs_reg [4];
    zset_t zs_in;
    assign zs_in.az = DEPTH_BITS'(az);
    assign zs_in.bz = DEPTH_BITS'(bz);
    assign zs_in.cz = DEPTH_BITS'(cz);

    logic signed [EW-1:0]  e1x_reg, e2x_reg, e1y_reg, e2y_reg;
    logic signed [PW-1:0]  muz1_reg, muz2_reg;
    logic signed [UW-1:0]  uz_reg;
    logic [NW-1:0]         auz4_reg, auz5_reg, auz6_reg;
    logic                  degen4_reg, degen5_reg, degen6_reg;
    logic [NSAMP-1:0]      cov4_reg, cov5_reg, cov6_reg;
    logic [NW-1:0]         auz_next;
    logic                  degen_next;
    logic signed [UW-1:0]  uz_next;

    assign uz_next  = UW'(muz1_reg) - UW'(muz2_reg);
    assign auz_next = uz_reg[UW-1] ? NW'(-NW'(uz_reg)) : NW'(uz_reg);
    assign degen_next = (auz_next <= AREA_THR);

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            zs_reg[0] <= zs_in;
            e1x_reg   <= EW'(cx) - EW'(ax);
            e2x_reg   <= EW'(bx) - EW'(ax);
            e1y_reg   <= EW'(cy) - EW'(ay);
            e2y_reg   <= EW'(by_coord) - EW'(ay);
        end
        if (adv[1])
        begin
            zs_reg[1] <= zs_reg[0];
            muz1_reg  <= PW'(e1x_reg) * PW'(e2y_reg);
            muz2_reg  <= PW'(e2x_reg) * PW'(e1y_reg);
        end
        if (adv[2])
        begin
            zs_reg[2] <= zs_reg[1];
            uz_reg    <= uz_next;
        end
        if (adv[3])
        begin
            zs_reg[3]  <= zs_reg[2];
            auz4_reg   <= auz_next;
            degen4_reg <= degen_next;
        end
        if (adv[4])
        begin
            auz5_reg   <= auz4_reg;
            degen5_reg <= degen4_reg;
            cov5_reg   <= cov4_reg;
        end
        if (adv[5])
        begin
            auz6_reg   <= auz5_reg;
            degen6_reg <= degen5_reg;
            cov6_reg   <= cov5_reg;
        end
    end

    logic [NUMW-1:0]       num_reg [NSAMP];
    logic [DEPTH_BITS-1:0] quo     [NSAMP];

    for (genvar s = 0; s < NSAMP; s++) begin : g_samp
        localparam logic [SXW-1:0] OFS_X =
            SXW'(((s % 2) == 1 ? 3 : 1) << (FRAC_BITS - 2));
        localparam logic [SXW-1:0] OFS_Y =
            SXW'(((s / 2) == 1 ? 3 : 1) << (FRAC_BITS - 2));

        logic [SXW-1:0]        sx, sy;
        logic signed [DXW-1:0] dx_reg, dy_reg;
        logic signed [PW-1:0]  mx1_reg, mx2_reg, my1_reg, my2_reg;
        logic signed [UW-1:0]  ux_reg, uy_reg;
        logic signed [NW-1:0]  n0, n1, n2, f0, f1, f2;
        logic [NW-1:0]         w0_reg, w1_reg, w2_reg;
        logic [MW-1:0]         p0_reg, p1_reg, p2_reg;
        logic                  cov_next;

        assign sx = (SXW'(pixel_x) << FRAC_BITS) + OFS_X;
        assign sy = (SXW'(pixel_y) << FRAC_BITS) + OFS_Y;

        assign n0 = NW'(uz_reg) - NW'(ux_reg) - NW'(uy_reg);
        assign n1 = NW'(uy_reg);
        assign n2 = NW'(ux_reg);
        assign f0 = uz_reg[UW-1] ? -n0 : n0;
        assign f1 = uz_reg[UW-1] ? -n1 : n1;
        assign f2 = uz_reg[UW-1] ? -n2 : n2;

        if (s < SAMPLES) begin : g_used
            assign cov_next = !f0[NW-1] && !f1[NW-1] && !f2[NW-1] && !degen_next;
        end else begin : g_unused
            assign cov_next = 1'b0;
        end

        always_ff @(posedge clk)
        begin
            if (adv[0])
            begin
                dx_reg <= DXW'(ax) - DXW'(signed'({1'b0, sx}));
                dy_reg <= DXW'(ay) - DXW'(signed'({1'b0, sy}));
            end
            if (adv[1])
            begin
                mx1_reg <= PW'(e2x_reg) * PW'(dy_reg);
                mx2_reg <= PW'(dx_reg) * PW'(e2y_reg);
                my1_reg <= PW'(dx_reg) * PW'(e1y_reg);
                my2_reg <= PW'(e1x_reg) * PW'(dy_reg);
            end
            if (adv[2])
            begin
                ux_reg <= UW'(mx1_reg) - UW'(mx2_reg);
                uy_reg <= UW'(my1_reg) - UW'(my2_reg);
            end
            if (adv[3])
            begin
                w0_reg <= f0;
                w1_reg <= f1;
                w2_reg <= f2;
            end
            if (adv[4])
            begin
                p0_reg <= MW'(zs_reg[3].az) * MW'(w0_reg);
                p1_reg <= MW'(zs_reg[3].bz) * MW'(w1_reg);
                p2_reg <= MW'(zs_reg[3].cz) * MW'(w2_reg);
            end
            if (adv[5])
            begin
                num_reg[s] <= NUMW'(p0_reg) + NUMW'(p1_reg) + NUMW'(p2_reg);
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[3])
            begin
                cov4_reg[s] <= cov_next;
            end
        end

        tscd_divider u_div (
            .clk    (clk),
            .adv    (adv[FRONT +: DEPTH_BITS]),
            .num_in (num_reg[s]),
            .den_in (auz6_reg),
            .quo    (quo[s])
        );
    end

    // Coverage and degenerate flag ride next to the divider stages.
    side_t side_reg [DEPTH_BITS];
    side_t side_in;
    assign side_in.cov   = cov6_reg;
    assign side_in.degen = degen6_reg;

    always_ff @(posedge clk)
    begin
        if (adv[FRONT])
        begin
            side_reg[0] <= side_in;
        end
        for (int k = 1; k < DEPTH_BITS; k++)
        begin
            if (adv[FRONT + k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    logic [3:0]  mask_reg;
    logic        degen_reg;
    logic [15:0] depth_reg [NSAMP];

    always_ff @(posedge clk)
    begin
        if (adv[LAST])
        begin
            mask_reg  <= side_reg[DEPTH_BITS-1].cov;
            degen_reg <= side_reg[DEPTH_BITS-1].degen;
            for (int s = 0; s < NSAMP; s++)
            begin
                depth_reg[s] <= side_reg[DEPTH_BITS-1].cov[s] ? 16'(quo[s]) : '0;
            end
        end
    end

    assign sample_mask = mask_reg;
    assign degenerate  = degen_reg;
    assign depth_s0    = depth_reg[0];
    assign depth_s1    = depth_reg[1];
    assign depth_s2    = depth_reg[2];
    assign depth_s3    = depth_reg[3];
endmodule
`default_nettype wire

### hw/rtl/tscd_checker.sv
// Port-level checker for the triangle sample coverage core, with its bind.
`default_nettype none
module tscd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [3:0]  sample_mask,
    input wire logic [15:0] depth_s0,
    input wire logic [15:0] depth_s1,
    input wire logic [15:0] depth_s2,
    input wire logic [15:0] depth_s3,
    input wire logic        degenerate
);
    // A stalled result stays offered.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A degenerate triangle covers nothing.
    a_degen_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> sample_mask == 4'd0)
        else $error("degenerate triangle with coverage");

    // Uncovered samples report depth zero.
    a_uncov_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sample_mask[0] || depth_s0 == 16'd0)
                   && (sample_mask[1] || depth_s1 == 16'd0)
                   && (sample_mask[2] || depth_s2 == 16'd0)
                   && (sample_mask[3] || depth_s3 == 16'd0))
        else $error("uncovered sample with nonzero depth");

    // A stalled result keeps its payload.
    a_stall_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({sample_mask, depth_s0, depth_s1,
                                             depth_s2, depth_s3, degenerate}))
        else $error("result changed while stalled");
endmodule

bind triangle_sample_coverage_depth_core tscd_checker u_tscd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_mask (sample_mask),
    .depth_s0    (depth_s0),
    .depth_s1    (depth_s1),
    .depth_s2    (depth_s2),
    .depth_s3    (depth_s3),
    .degenerate  (degenerate)
);
`default_nettype wire

### bench/triangle_sample_coverage_depth_checker.sv
// Checker that predicts the coverage mask, sample depths and degenerate flag and compares them with the block.
`default_nettype none
module triangle_sample_coverage_depth_checker
    import tscd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_ready,
    input  wire logic signed [CW-1:0] ax,
    input  wire logic signed [CW-1:0] ay,
    input  wire logic [ZW-1:0]        az,
    input  wire logic signed [CW-1:0] bx,
    input  wire logic signed [CW-1:0] by_coord,
    input  wire logic [ZW-1:0]        bz,
    input  wire logic signed [CW-1:0] cx,
    input  wire logic signed [CW-1:0] cy,
    input  wire logic [ZW-1:0]        cz,
    input  wire logic [PIXW-1:0]      pixel_x,
    input  wire logic [PIXW-1:0]      pixel_y,
    input  wire logic                 out_valid,
    input  wire logic                 out_ready,
    input  wire logic [3:0]           sample_mask,
    input  wire logic [15:0]          depth_s0,
    input  wire logic [15:0]          depth_s1,
    input  wire logic [15:0]          depth_s2,
    input  wire logic [15:0]          depth_s3,
    input  wire logic                 degenerate,
    output int                        fail_count,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]  mask;
        logic [15:0] d0;
        logic [15:0] d1;
        logic [15:0] d2;
        logic [15:0] d3;
        logic        degen;
    } coverage_t;

    coverage_t coverage_q[$];

    function automatic coverage_t shade_pixel(
        logic signed [15:0] pax, logic signed [15:0] pay, logic [15:0] paz,
        logic signed [15:0] pbx, logic signed [15:0] pby, logic [15:0] pbz,
        logic signed [15:0] pcx, logic signed [15:0] pcy, logic [15:0] pcz,
        logic [10:0] px, logic [10:0] py);
        coverage_t r;
        longint e1x, e2x, e1y, e2y, area, aarea, thr, sx, sy, dx, dy, ux, uy;
        longint n0, n1, n2;
        logic [127:0] num;
        logic [127:0] quo;
        logic [15:0] dq;
        r = '0;
        e1x = longint'(pcx) - longint'(pax);
        e2x = longint'(pbx) - longint'(pax);
        e1y = longint'(pcy) - longint'(pay);
        e2y = longint'(pby) - longint'(pay);
        area = e1x * e2y - e2x * e1y;
        aarea = (area < 0) ? -area : area;
        thr = (64'd9 << (2 * FRAC_BITS)) / 10;
        if (aarea <= thr) begin
            r.degen = 1'b1;
            return r;
        end
        for (int i = 0; i < SAMPLES && i < 4; i++) begin
            sx = longint'(px) * (64'd1 << FRAC_BITS)
                 + (((i & 1) ? 64'd3 : 64'd1) << (FRAC_BITS - 2));
            sy = longint'(py) * (64'd1 << FRAC_BITS)
                 + (((i & 2) ? 64'd3 : 64'd1) << (FRAC_BITS - 2));
            dx = longint'(pax) - sx;
            dy = longint'(pay) - sy;
            ux = e2x * dy - dx * e2y;
            uy = dx * e1y - e1x * dy;
            n0 = area - ux - uy;
            n1 = uy;
            n2 = ux;
            if (area < 0) begin
                n0 = -n0;
                n1 = -n1;
                n2 = -n2;
            end
            if (n0 < 0 || n1 < 0 || n2 < 0)
                continue;
            r.mask[i] = 1'b1;
            num = 128'(paz) * 128'(n0) + 128'(pbz) * 128'(n1) + 128'(pcz) * 128'(n2);
            quo = num / 128'(aarea);
            dq = quo[15:0];
            case (i)
                0: r.d0 = dq;
                1: r.d1 = dq;
                2: r.d2 = dq;
                default: r.d3 = dq;
            endcase
        end
        return r;
    endfunction

    initial fail_count = 0;
    assign pending = coverage_q.size();

    always @(posedge clk) begin
        coverage_t want;
        if (rst_n && in_valid && in_ready)
            coverage_q.push_back(shade_pixel(ax, ay, az, bx, by_coord, bz,
                                             cx, cy, cz, pixel_x, pixel_y));
        if (rst_n && out_valid && out_ready) begin
            if (coverage_q.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_count++;
            end else begin
                want = coverage_q.pop_front();
                if (sample_mask !== want.mask) begin
                    $error("sample_mask: expected %h, got %h", want.mask, sample_mask);
                    fail_count++;
                end
                if (depth_s0 !== want.d0) begin
                    $error("depth_s0: expected %0d, got %0d", want.d0, depth_s0);
                    fail_count++;
                end
                if (depth_s1 !== want.d1) begin
                    $error("depth_s1: expected %0d, got %0d", want.d1, depth_s1);
                    fail_count++;
                end
                if (depth_s2 !== want.d2) begin
                    $error("depth_s2: expected %0d, got %0d", want.d2, depth_s2);
                    fail_count++;
                end
                if (depth_s3 !== want.d3) begin
                    $error("depth_s3: expected %0d, got %0d", want.d3, depth_s3);
                    fail_count++;
                end
                if (degenerate !== want.degen) begin
                    $error("degenerate: expected %b, got %b", want.degen, degenerate);
                    fail_count++;
                end
            end
        end
    end
endmodule
`default_nettype wire

### bench/triangle_sample_coverage_depth_core_tb.sv
// Testbench top: drives triangles and pixels into the coverage core and gives the verdict.
`default_nettype none
module triangle_sample_coverage_depth_core_tb;
    import tscd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1800;
    localparam int CYCLE_LIMIT  = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [CW-1:0] ax = '0, ay = '0, bx = '0, by_coord = '0, cx = '0, cy = '0;
    logic [ZW-1:0] az = '0, bz = '0, cz = '0;
    logic [PIXW-1:0] pixel_x = '0, pixel_y = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [3:0] sample_mask;
    logic [15:0] depth_s0, depth_s1, depth_s2, depth_s3;
    logic degenerate;
    int fail_count;
    int pending;
    int cycles = 0;
    bit calm = 1'b0;

    always #6 clk = ~clk;

    triangle_sample_coverage_depth_core dut (.*);
    triangle_sample_coverage_depth_checker chk (.*);

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver stalls in bursts until the quiet tail of the run.
    initial begin
        int n;
        forever begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 13);
                repeat (n) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic send_triangle(input logic [15:0] tax, tay, taz, tbx, tby, tbz,
                                 tcx, tcy, tcz, input logic [10:0] tpx, tpy);
        int n;
        if (!calm && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            n = $urandom_range(1, 13);
            repeat (n) @(negedge clk);
        end
        ax <= tax; ay <= tay; az <= taz;
        bx <= tbx; by_coord <= tby; bz <= tbz;
        cx <= tcx; cy <= tcy; cz <= tcz;
        pixel_x <= tpx; pixel_y <= tpy;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Triangle near a pixel, small in most cases, so most samples land close to an edge.
    task automatic send_near_pixel();
        logic [10:0] px, py;
        int base_x, base_y, span;
        px = $urandom_range(0, 2047);
        py = $urandom_range(0, 2047);
        span = ($urandom_range(0, 3) == 0) ? 2000 : 40;
        base_x = int'(px) * 16;
        base_y = int'(py) * 16;
        if (base_x > 32000) base_x = 32000;
        if (base_y > 32000) base_y = 32000;
        send_triangle(16'(base_x + $urandom_range(0, span) - span / 4),
                      16'(base_y + $urandom_range(0, span) - span / 4), 16'($urandom),
                      16'(base_x + $urandom_range(0, span) - span / 4),
                      16'(base_y + $urandom_range(0, span) - span / 4), 16'($urandom),
                      16'(base_x + $urandom_range(0, span) - span / 4),
                      16'(base_y + $urandom_range(0, span) - span / 4), 16'($urandom),
                      px, py);
    endtask

    initial begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Pixel (0,0) fully inside, both windings, edge on a sample, degenerate, extremes.
        send_triangle(16'sd0, 16'sd0, 16'd100, 16'sd64, 16'sd0, 16'd200,
                      16'sd0, 16'sd64, 16'd300, 11'd0, 11'd0);
        send_triangle(16'sd0, 16'sd0, 16'd100, 16'sd0, 16'sd64, 16'd300,
                      16'sd64, 16'sd0, 16'd200, 11'd0, 11'd0);
        send_triangle(16'sd4, 16'sd4, 16'hFFFF, 16'sd12, 16'sd4, 16'hFFFF,
                      16'sd4, 16'sd12, 16'hFFFF, 11'd0, 11'd0);
        send_triangle(16'sd0, 16'sd0, 16'd5, 16'sd16, 16'sd0, 16'd5,
                      16'sd0, 16'sd14, 16'd5, 11'd0, 11'd0);
        send_triangle(16'sd0, 16'sd0, 16'd5, 16'sd16, 16'sd0, 16'd5,
                      16'sd0, 16'sd15, 16'd5, 11'd0, 11'd0);
        send_triangle(16'sd0, 16'sd0, 16'd5, 16'sd16, 16'sd0, 16'd5,
                      16'sd0, 16'sd0, 16'd5, 11'd0, 11'd0);
        send_triangle(16'h8000, 16'h8000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'd0,
                      16'h8000, 16'h7FFF, 16'hAAAA, 11'd2047, 11'd2047);
        send_triangle(16'h8000, 16'h8000, 16'd0, 16'h7FFF, 16'h7FFF, 16'hFFFF,
                      16'h7FFF, 16'h8000, 16'h5555, 11'd0, 11'd2047);
        send_triangle(16'h7FFF, 16'h7FFF, 16'd1, 16'h8000, 16'h7FFF, 16'd2,
                      16'h7FFF, 16'h8000, 16'd3, 11'd2047, 11'd0);
        send_triangle(16'sd0, 16'sd0, 16'd0, 16'sd32752, 16'sd0, 16'hFFFF,
                      16'sd0, 16'sd32752, 16'hFFFF, 11'd2046, 11'd1);
        send_triangle(16'sd100, 16'sd100, 16'd9, 16'sd200, 16'sd100, 16'd9,
                      16'sd300, 16'sd100, 16'd9, 11'd10, 11'd6);

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - 200) calm = 1'b1;
            if (i % 6 == 0)
                send_triangle(16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom), 16'($urandom),
                              11'($urandom), 11'($urandom));
            else
                send_near_pixel();
            if (i == RANDOM_ITEMS / 2) begin
                in_valid <= 1'b0;
                while (pending != 0) @(negedge clk);
            end
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (30) @(negedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
